// ===== rtl/core/fgra_pkg.sv =====
// ============================================================================
// fgra_pkg
// Shared types and codes of the fence-gated range allocator.
// ============================================================================
package fgra_pkg;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;

    localparam logic [8:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic        is_release;
        logic [8:0]  range_count;
        logic [7:0]  range_offset;
        logic [63:0] fence;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] alloc_offset;
    } t_result;

endpackage

// ===== rtl/core/fgra_if.sv =====
// ============================================================================
// fgra_if
// Channel interfaces: request items, results and the capacity register write.
// ============================================================================
interface fgra_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [8:0]  range_count;
    logic [7:0]  range_offset;
    logic [63:0] fence;
    logic        last_of_batch;

    modport source (output valid, opcode, range_count, range_offset, fence, last_of_batch,
                    input ready);
    modport sink   (input valid, opcode, range_count, range_offset, fence, last_of_batch,
                    output ready);
endinterface

interface fgra_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] alloc_offset;

    modport source (output valid, status, alloc_offset, input ready);
    modport sink   (input valid, status, alloc_offset, output ready);
endinterface

interface fgra_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/fgra_front.sv =====
// ============================================================================
// fgra_front
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ============================================================================
module fgra_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    fgra_item_if.sink            i_item,
    output fgra_pkg::t_cmd       o_cmd,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready
);

    fgra_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;
    fgra_pkg::t_cmd w_cmd;

    assign i_item.ready = i_en && (r_cnt != 2'd2);
    assign w_push       = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_cnt != 2'd0);
    assign w_pop        = o_cmd_valid && i_cmd_ready;
    assign o_cmd        = r_q[r_rp];

    always_comb begin
        w_cmd.is_release   = (i_item.opcode == fgra_pkg::OP_RELEASE);
        w_cmd.range_count  = i_item.range_count;
        w_cmd.range_offset = i_item.range_offset;
        w_cmd.fence        = i_item.fence;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/fgra_back.sv =====
// ============================================================================
// fgra_back
// Sequencer that carries out releases and allocations over the slot map
// and the pending-release memories, one step per cycle.
// ============================================================================
module fgra_back #(
    parameter int SLOTS         = 256,
    parameter int PENDING_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [8:0]     i_cap,
    input  fgra_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    output logic           o_init_done,
    fgra_res_if.source     o_result
);

    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1024);
    localparam int PW = $clog2(PENDING_DEPTH);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_REL  = 4'd2;
    localparam logic [3:0] S_FRD  = 4'd3;
    localparam logic [3:0] S_FCK  = 4'd4;
    localparam logic [3:0] S_FREE = 4'd5;
    localparam logic [3:0] S_SRD  = 4'd6;
    localparam logic [3:0] S_SCK  = 4'd7;
    localparam logic [3:0] S_MARK = 4'd8;

    logic              m_used [SLOTS];
    logic [7:0]        m_off  [PENDING_DEPTH];
    logic [8:0]        m_cnt  [PENDING_DEPTH];
    logic [63:0]       m_fen  [PENDING_DEPTH];

    logic [3:0]        r_state, n_state;
    fgra_pkg::t_cmd    r_cmd, n_cmd;
    logic [PW:0]       r_e, n_e;
    logic [LW-1:0]     r_slot, n_slot;
    logic [8:0]        r_left, n_left;
    logic [8:0]        r_run, n_run;
    logic [LW-1:0]     r_i, n_i;
    logic [LW-1:0]     r_start, n_start;
    logic [7:0]        r_min, n_min;
    logic              r_rel, n_rel;
    logic [PENDING_DEPTH-1:0] r_valid, n_valid;
    fgra_pkg::t_result r_res, n_res;
    logic              r_res_vld, n_res_vld;

    logic              r_rd_used;
    logic [7:0]        r_rd_off;
    logic [8:0]        r_rd_cnt;
    logic [63:0]       r_rd_fen;

    logic              w_uwe;
    logic              w_uwd;
    logic              w_ure;
    logic              w_pwe;
    logic              w_pre;
    logic [LW-1:0]     w_cap;
    logic [LW-1:0]     w_first;
    logic [PW-1:0]     w_eidx;

    assign w_eidx       = r_e[PW-1:0];
    assign w_cap        = (LW'(i_cap) > LW'(SLOTS)) ? LW'(SLOTS) : LW'(i_cap);
    assign w_first      = r_i + LW'(1) - LW'(r_cmd.range_count);
    assign o_init_done  = (r_state != S_CLR);
    assign o_cmd_ready  = (r_state == S_IDLE) && (!r_res_vld || o_result.ready);
    assign o_result.valid        = r_res_vld;
    assign o_result.status       = r_res.status;
    assign o_result.alloc_offset = r_res.alloc_offset;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_e       = r_e;
        n_slot    = r_slot;
        n_left    = r_left;
        n_run     = r_run;
        n_i       = r_i;
        n_start   = r_start;
        n_min     = r_min;
        n_rel     = r_rel;
        n_valid   = r_valid;
        n_res     = r_res;
        n_res_vld = r_res_vld;
        w_uwe     = 1'b0;
        w_uwd     = 1'b0;
        w_ure     = 1'b0;
        w_pwe     = 1'b0;
        w_pre     = 1'b0;

        if (r_res_vld && o_result.ready) begin
            n_res_vld = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                w_uwe  = 1'b1;
                n_slot = r_slot + LW'(1);
                if (r_slot == LW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_cmd = i_cmd;
                    n_e   = '0;
                    n_rel = 1'b0;
                    n_min = '0;
                    n_state = i_cmd.is_release ? S_REL : S_FRD;
                end
            end
            S_REL: begin
                if (r_e == (PW+1)'(PENDING_DEPTH)) begin
                    n_res.status       = fgra_pkg::ST_LIST_FULL;
                    n_res.alloc_offset = '0;
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else if (!r_valid[w_eidx]) begin
                    w_pwe              = 1'b1;
                    n_valid[w_eidx]    = 1'b1;
                    n_res.status       = fgra_pkg::ST_OK;
                    n_res.alloc_offset = '0;
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_e = r_e + (PW+1)'(1);
                end
            end
            S_FRD: begin
                if (r_e == (PW+1)'(PENDING_DEPTH)) begin
                    if (r_rel) begin
                        n_start = LW'(r_min);
                    end
                    if (r_cmd.range_count == 9'd0) begin
                        n_res.status       = fgra_pkg::ST_NO_SPACE;
                        n_res.alloc_offset = '0;
                        n_res_vld = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_i     = r_rel ? LW'(r_min) : r_start;
                        n_run   = '0;
                        n_state = S_SRD;
                    end
                end else begin
                    w_pre   = 1'b1;
                    n_state = S_FCK;
                end
            end
            S_FCK: begin
                if (r_valid[w_eidx] && (r_rd_fen <= r_cmd.fence)) begin
                    if (!r_rel || (r_rd_off < r_min)) begin
                        n_min = r_rd_off;
                    end
                    n_rel           = 1'b1;
                    n_valid[w_eidx] = 1'b0;
                    n_slot          = LW'(r_rd_off);
                    n_left          = r_rd_cnt;
                    n_state         = S_FREE;
                end else begin
                    n_e     = r_e + (PW+1)'(1);
                    n_state = S_FRD;
                end
            end
            S_FREE: begin
                if ((r_left == 9'd0) || (r_slot >= LW'(SLOTS))) begin
                    n_e     = r_e + (PW+1)'(1);
                    n_state = S_FRD;
                end else begin
                    w_uwe  = 1'b1;
                    n_slot = r_slot + LW'(1);
                    n_left = r_left - 9'd1;
                end
            end
            S_SRD: begin
                if (r_i >= w_cap) begin
                    n_res.status       = fgra_pkg::ST_NO_SPACE;
                    n_res.alloc_offset = '0;
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    w_ure   = 1'b1;
                    n_state = S_SCK;
                end
            end
            S_SCK: begin
                if (r_rd_used) begin
                    n_run   = '0;
                    n_i     = r_i + LW'(1);
                    n_state = S_SRD;
                end else if ((r_run + 9'd1) >= r_cmd.range_count) begin
                    n_slot             = w_first;
                    n_left             = r_cmd.range_count;
                    n_start            = w_first + LW'(r_cmd.range_count);
                    n_res.alloc_offset = w_first[7:0];
                    n_state            = S_MARK;
                end else begin
                    n_run   = r_run + 9'd1;
                    n_i     = r_i + LW'(1);
                    n_state = S_SRD;
                end
            end
            S_MARK: begin
                if (r_left == 9'd0) begin
                    n_res.status = fgra_pkg::ST_OK;
                    n_res_vld    = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    w_uwe  = 1'b1;
                    w_uwd  = 1'b1;
                    n_slot = r_slot + LW'(1);
                    n_left = r_left - 9'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_uwe) begin
            m_used[r_slot[AW-1:0]] <= w_uwd;
        end
        if (w_ure) begin
            r_rd_used <= m_used[r_i[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            m_off[w_eidx] <= r_cmd.range_offset;
            m_cnt[w_eidx] <= r_cmd.range_count;
            m_fen[w_eidx] <= r_cmd.fence;
        end
        if (w_pre) begin
            r_rd_off <= m_off[w_eidx];
            r_rd_cnt <= m_cnt[w_eidx];
            r_rd_fen <= m_fen[w_eidx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_left <= n_left;
        r_run  <= n_run;
        r_i    <= n_i;
        r_min  <= n_min;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_slot    <= '0;
            r_e       <= '0;
            r_rel     <= 1'b0;
            r_start   <= '0;
            r_valid   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slot    <= n_slot;
            r_e       <= n_e;
            r_rel     <= n_rel;
            r_start   <= n_start;
            r_valid   <= n_valid;
            r_res_vld <= n_res_vld;
        end
    end

endmodule

// ===== rtl/core/fence_gated_range_allocator.sv =====
// ============================================================================
// fence_gated_range_allocator
// Next-fit contiguous slot range allocator with fence-gated deferred release.
//
//   Channel   Dir  Payload
//   i_item    in   opcode, range_count, range_offset, fence, last_of_batch
//   o_result  out  status, alloc_offset
//   i_cfg     in   data (dynamic capacity)
//
// A release beat walks the pending valid bits for a free entry. An allocate
// beat walks the pending list, frees the slots of each entry whose fence is
// at or below its own, then scans the single-port slot map for a free run
// and marks it, one slot at a time.
// After reset a clearing pass over the slot map runs before any beat is taken.
// Up to two beats queue ahead of the sequencer while a result waits.
// ============================================================================
module fence_gated_range_allocator #(
    parameter int SLOTS         = 256,
    parameter int PENDING_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fgra_item_if.sink   i_item,
    fgra_res_if.source  o_result,
    fgra_cfg_if.sink    i_cfg
);

    logic [8:0]     r_cap;
    fgra_pkg::t_cmd w_cmd;
    logic           w_cmd_valid;
    logic           w_cmd_ready;
    logic           w_init_done;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= fgra_pkg::CAP_RESET;
        end else if (i_cfg.valid) begin
            r_cap <= i_cfg.data;
        end
    end

    fgra_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_init_done),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready)
    );

    fgra_back #(
        .SLOTS         (SLOTS),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .o_init_done (w_init_done),
        .o_result    (o_result)
    );

endmodule
